FILE: hdl/msfd_pkg.sv
// Package for the motor status frame decoder.
// Holds frame constants, body byte positions, status codes, shared types
// and the byte-wise CRC-8 function. Depends on nothing.
`default_nettype none

package msfd_pkg;

    localparam logic [7:0] HDR0      = 8'h55;
    localparam logic [7:0] HDR1      = 8'hAA;
    localparam logic [7:0] TRL0      = 8'h0D;
    localparam logic [7:0] TRL1      = 8'h0A;
    localparam logic [7:0] CRC_POLY  = 8'h8C;
    localparam logic [7:0] FIXED_LEN = 8'd7;

    // positions of the bytes that follow the header
    localparam logic [3:0] IDX_LEN  = 4'd0;
    localparam logic [3:0] IDX_PAY0 = 4'd1;
    localparam logic [3:0] IDX_PAY6 = 4'd7;
    localparam logic [3:0] IDX_CRC  = 4'd8;
    localparam logic [3:0] IDX_TRL0 = 4'd9;
    localparam logic [3:0] IDX_TRL1 = 4'd10;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_BAD_CRC = 2'd2;
    localparam logic [1:0] ST_BAD_TRL = 2'd3;

    typedef struct packed {
        logic [3:0] idx;
        logic [7:0] data;
    } t_body_item;

    typedef struct packed {
        logic [15:0] left_speed;
        logic [15:0] right_speed;
        logic [15:0] steer_angle;
        logic [7:0]  control_flag;
        logic [1:0]  status;
    } t_result;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // CRC state after the two header bytes
    localparam logic [7:0] HDR_CRC = crc8_byte(crc8_byte(8'h00, HDR0), HDR1);

endpackage

`default_nettype wire

FILE: hdl/msfd_queue.sv
// Two-entry queue of body bytes between the front and back parts.
// Depends on msfd_pkg for the body item type.
`default_nettype none

module msfd_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  msfd_pkg::t_body_item i_item,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_empty,
    output msfd_pkg::t_body_item o_item
);

    msfd_pkg::t_body_item r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("body queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("body queue written while full");

endmodule

`default_nettype wire

FILE: hdl/msfd_front.sv
// Front part: hunts for the frame header and tags each body byte with its
// position. Depends on msfd_pkg.
`default_nettype none

module msfd_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wire  [7:0]           i_byte,
    output logic                 o_push,
    output msfd_pkg::t_body_item o_item
);

    typedef enum logic [2:0] {
        FS_HUNT    = 3'b001,
        FS_WAIT_AA = 3'b010,
        FS_BODY    = 3'b100
    } t_front_state;

    t_front_state r_state;
    t_front_state n_state;
    logic [3:0]   r_idx;
    logic [3:0]   n_idx;

    assign o_item.idx  = r_idx;
    assign o_item.data = i_byte;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_push  = 1'b0;
        if (i_valid) begin
            unique case (r_state)
                FS_HUNT: begin
                    if (i_byte == msfd_pkg::HDR0) begin
                        n_state = FS_WAIT_AA;
                    end
                end
                FS_WAIT_AA: begin
                    priority if (i_byte == msfd_pkg::HDR1) begin
                        n_state = FS_BODY;
                        n_idx   = msfd_pkg::IDX_LEN;
                    end else if (i_byte == msfd_pkg::HDR0) begin
                        n_state = FS_WAIT_AA;
                    end else begin
                        n_state = FS_HUNT;
                    end
                end
                FS_BODY: begin
                    o_push = 1'b1;
                    if (r_idx == msfd_pkg::IDX_TRL1) begin
                        n_state = FS_HUNT;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
                default: begin
                    n_state = FS_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_HUNT;
            r_idx   <= msfd_pkg::IDX_LEN;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_BODY) |-> (r_idx <= msfd_pkg::IDX_TRL1))
        else $error("body position beyond trailer");

endmodule

`default_nettype wire

FILE: hdl/msfd_back.sv
// Back part: stores body bytes, runs the CRC, checks the frame and queues
// the decoded result in a two-entry result queue. Depends on msfd_pkg.
`default_nettype none

module msfd_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_empty,
    input  msfd_pkg::t_body_item i_item,
    output logic                 o_pop,
    input  wire                  i_pop,
    output logic                 o_empty,
    output msfd_pkg::t_result    o_result
);

    logic [7:0] r_crc;
    logic [7:0] r_len;
    logic [7:0] r_pay [7];
    logic [7:0] r_crc_seen;
    logic [7:0] r_trl0;

    msfd_pkg::t_result r_res [2];
    logic              r_res_wp;
    logic              r_res_rp;
    logic [1:0]        r_res_cnt;
    logic [1:0]        n_res_cnt;

    logic              w_is_last;
    logic              w_res_full;
    logic              w_res_push;
    logic              w_res_pop;
    logic [2:0]        w_pay_sel;
    logic [1:0]        w_status;
    msfd_pkg::t_result w_result;

    assign w_is_last  = (i_item.idx == msfd_pkg::IDX_TRL1);
    assign w_res_full = (r_res_cnt == 2'd2);
    assign o_pop      = !i_empty && (!w_is_last || !w_res_full);
    assign w_res_push = o_pop && w_is_last;
    assign w_res_pop  = i_pop && !o_empty;
    assign w_pay_sel  = 3'(i_item.idx - msfd_pkg::IDX_PAY0);
    assign o_empty    = (r_res_cnt == 2'd0);
    assign o_result   = r_res[r_res_rp];

    always_comb begin
        priority if (r_len != msfd_pkg::FIXED_LEN) begin
            w_status = msfd_pkg::ST_BAD_LEN;
        end else if (r_crc_seen != r_crc) begin
            w_status = msfd_pkg::ST_BAD_CRC;
        end else if (r_trl0 != msfd_pkg::TRL0 || i_item.data != msfd_pkg::TRL1) begin
            w_status = msfd_pkg::ST_BAD_TRL;
        end else begin
            w_status = msfd_pkg::ST_OK;
        end
        w_result.left_speed   = {r_pay[1], r_pay[0]};
        w_result.right_speed  = {r_pay[3], r_pay[2]};
        w_result.steer_angle  = {r_pay[5], r_pay[4]};
        w_result.control_flag = r_pay[6];
        w_result.status       = w_status;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            priority if (i_item.idx == msfd_pkg::IDX_LEN) begin
                r_len <= i_item.data;
                r_crc <= msfd_pkg::crc8_byte(msfd_pkg::HDR_CRC, i_item.data);
            end else if (i_item.idx >= msfd_pkg::IDX_PAY0
                         && i_item.idx <= msfd_pkg::IDX_PAY6) begin
                r_pay[w_pay_sel] <= i_item.data;
                r_crc <= msfd_pkg::crc8_byte(r_crc, i_item.data);
            end else if (i_item.idx == msfd_pkg::IDX_CRC) begin
                r_crc_seen <= i_item.data;
            end else if (i_item.idx == msfd_pkg::IDX_TRL0) begin
                r_trl0 <= i_item.data;
            end else begin
                r_trl0 <= r_trl0;
            end
        end
    end

    always_comb begin
        n_res_cnt = r_res_cnt;
        if (w_res_push && !w_res_pop) begin
            n_res_cnt = r_res_cnt + 2'd1;
        end else if (w_res_pop && !w_res_push) begin
            n_res_cnt = r_res_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wp  <= 1'b0;
            r_res_rp  <= 1'b0;
            r_res_cnt <= 2'd0;
        end else begin
            r_res_cnt <= n_res_cnt;
            if (w_res_push) begin
                r_res_wp <= !r_res_wp;
            end
            if (w_res_pop) begin
                r_res_rp <= !r_res_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_push) begin
            r_res[r_res_wp] <= w_result;
        end
    end

    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_cnt <= 2'd2)
        else $error("result queue count out of range");

    a_res_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> (i_item.idx == msfd_pkg::IDX_TRL1 && !w_res_full))
        else $error("result queued outside frame end");

endmodule

`default_nettype wire

FILE: hdl/motor_status_frame_decoder.sv
// Motor status frame decoder: 0x55 0xAA LEN P0..P6 CRC 0x0D 0x0A frames.
// Throughput: one byte per cycle while the body queue is not full, set by the
// front phase register and the byte-wise CRC-8 step in the back part.
// Result path: the last trailer byte is written into the body queue; the back
// part then writes the decoded result into the result queue once it has room.
// Reset: synchronous, active low; clears phase and queues, no clearing pass.
`default_nettype none

module motor_status_frame_decoder (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               push,
    output logic              full,
    input  wire  [7:0]        i_rx_byte,
    output logic              empty,
    input  wire               pop,
    output logic signed [15:0] o_left_speed,
    output logic signed [15:0] o_right_speed,
    output logic signed [15:0] o_steer_angle,
    output logic [7:0]        o_control_flag,
    output logic [1:0]        o_status
);

    logic                 w_accept;
    logic                 w_front_push;
    msfd_pkg::t_body_item w_front_item;
    logic                 w_q_empty;
    logic                 w_q_pop;
    msfd_pkg::t_body_item w_q_item;
    msfd_pkg::t_result    w_result;

    assign w_accept = push && !full;

    msfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_byte  (i_rx_byte),
        .o_push  (w_front_push),
        .o_item  (w_front_item)
    );

    msfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_item  (w_front_item),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_item  (w_q_item)
    );

    msfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_q_empty),
        .i_item   (w_q_item),
        .o_pop    (w_q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (w_result)
    );

    assign o_left_speed   = signed'(w_result.left_speed);
    assign o_right_speed  = signed'(w_result.right_speed);
    assign o_steer_angle  = signed'(w_result.steer_angle);
    assign o_control_flag = w_result.control_flag;
    assign o_status       = w_result.status;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for motor_status_frame_decoder: drives 0x55 0xAA framed byte streams
// with random flaws, noise and stalls, and checks each decoded frame against a local decoder.
// Depends on msfd_pkg and the decoder RTL.

module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_TAIL     = 8;
    localparam int MAX_PRINTS     = 40;

    localparam logic [3:0] PH_HUNT      = 4'd0;
    localparam logic [3:0] PH_SYNC      = 4'd1;
    localparam logic [3:0] PH_LEN       = 4'd2;
    localparam logic [3:0] PH_PAY_FIRST = 4'd3;
    localparam logic [3:0] PH_PAY_LAST  = 4'd9;
    localparam logic [3:0] PH_CRC       = 4'd10;
    localparam logic [3:0] PH_TRL0      = 4'd11;
    localparam logic [3:0] PH_TRL1      = 4'd12;

    typedef enum int {
        FLAW_NONE,
        FLAW_LEN,
        FLAW_CRC,
        FLAW_TRL0,
        FLAW_TRL1,
        FLAW_ALL
    } t_frame_flaw;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push    = 1'b0;
    logic               full;
    logic [7:0]         rx_byte = 8'h00;
    logic               empty;
    logic               pop     = 1'b0;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic signed [15:0] steer_angle;
    logic [7:0]         control_flag;
    logic [1:0]         status;

    msfd_pkg::t_result frames_due [$];
    msfd_pkg::t_result frame_head;

    logic [3:0] dec_phase = PH_HUNT;
    logic [7:0] dec_crc   = 8'h00;
    logic [7:0] dec_len;
    logic [7:0] dec_crc_rx;
    logic [7:0] dec_trl0;
    logic [7:0] dec_payload [7];

    int          mismatches     = 0;
    int          bytes_sent     = 0;
    int          frames_sent    = 0;
    int          frames_checked = 0;
    int          burst_left     = 0;
    int          idle_cycles    = 0;
    int          pop_tick       = 0;
    int          status_seen [4] = '{0, 0, 0, 0};
    logic [15:0] stall_pattern  = 16'hFFFF;

    motor_status_frame_decoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_rx_byte      (rx_byte),
        .empty          (empty),
        .pop            (pop),
        .o_left_speed   (left_speed),
        .o_right_speed  (right_speed),
        .o_steer_angle  (steer_angle),
        .o_control_flag (control_flag),
        .o_status       (status)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            r = (r[0] ^ data[i]) ? ((r >> 1) ^ msfd_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        msfd_pkg::t_result fr;
        logic [1:0]        st;
        if (dec_phase == PH_SYNC) begin
            if (b == msfd_pkg::HDR1) begin
                dec_crc   = crc8_step(dec_crc, b);
                dec_phase = PH_LEN;
            end else if (b == msfd_pkg::HDR0) begin
                dec_crc = crc8_step(8'h00, b);
            end else begin
                dec_phase = PH_HUNT;
            end
        end else if (dec_phase == PH_LEN) begin
            dec_len   = b;
            dec_crc   = crc8_step(dec_crc, b);
            dec_phase = PH_PAY_FIRST;
        end else if (dec_phase >= PH_PAY_FIRST && dec_phase <= PH_PAY_LAST) begin
            dec_payload[3'(dec_phase - PH_PAY_FIRST)] = b;
            dec_crc   = crc8_step(dec_crc, b);
            dec_phase = dec_phase + 4'd1;
        end else if (dec_phase == PH_CRC) begin
            dec_crc_rx = b;
            dec_phase  = PH_TRL0;
        end else if (dec_phase == PH_TRL0) begin
            dec_trl0  = b;
            dec_phase = PH_TRL1;
        end else if (dec_phase == PH_TRL1) begin
            if (dec_len != msfd_pkg::FIXED_LEN)
                st = msfd_pkg::ST_BAD_LEN;
            else if (dec_crc_rx != dec_crc)
                st = msfd_pkg::ST_BAD_CRC;
            else if (dec_trl0 != msfd_pkg::TRL0 || b != msfd_pkg::TRL1)
                st = msfd_pkg::ST_BAD_TRL;
            else
                st = msfd_pkg::ST_OK;
            fr.left_speed   = {dec_payload[1], dec_payload[0]};
            fr.right_speed  = {dec_payload[3], dec_payload[2]};
            fr.steer_angle  = {dec_payload[5], dec_payload[4]};
            fr.control_flag = dec_payload[6];
            fr.status       = st;
            frames_due.insert(frames_due.size(), fr);
            dec_phase = PH_HUNT;
            dec_crc   = 8'h00;
        end else if (b == msfd_pkg::HDR0) begin
            dec_crc   = crc8_step(8'h00, b);
            dec_phase = PH_SYNC;
        end else begin
            dec_phase = PH_HUNT;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        decode_byte(b);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 15);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [55:0] pay,
                              input logic [7:0] crc_flip, input logic [7:0] t0,
                              input logic [7:0] t1);
        logic [7:0] crc;
        crc = crc8_step(crc8_step(8'h00, msfd_pkg::HDR0), msfd_pkg::HDR1);
        crc = crc8_step(crc, len);
        for (int i = 0; i < 7; i++) crc = crc8_step(crc, pay[8*i +: 8]);
        send_byte(msfd_pkg::HDR0);
        send_byte(msfd_pkg::HDR1);
        send_byte(len);
        for (int i = 0; i < 7; i++) send_byte(pay[8*i +: 8]);
        send_byte(crc ^ crc_flip);
        send_byte(t0);
        send_byte(t1);
        frames_sent++;
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // header mismatch, repeated 0x55, then a clean frame with extreme values
    task automatic test_header_hunt();
        send_byte(msfd_pkg::HDR0);
        send_byte(8'h12);
        send_byte(msfd_pkg::HDR0);
        send_frame(msfd_pkg::FIXED_LEN, {8'h00, 16'hFFFF, 16'h8000, 16'h7FFF}, 8'h00,
                   msfd_pkg::TRL0, msfd_pkg::TRL1);
    endtask

    // bad length holding a header byte, bad crc and bad trailer together
    task automatic test_error_priority();
        send_frame(msfd_pkg::HDR0, {8'hFF, 16'h0000, 16'hFFFF, 16'h8001}, 8'h3C,
                   msfd_pkg::HDR1, msfd_pkg::HDR0);
    endtask

    task automatic test_random_traffic(input int target);
        int          frame_bytes;
        int          pick;
        int          n;
        t_frame_flaw flaw;
        logic [7:0]  len;
        logic [7:0]  flip;
        logic [7:0]  t0;
        logic [7:0]  t1;
        logic [7:0]  b;
        logic [55:0] pay;
        frame_bytes = 0;
        while (frame_bytes < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
                case ($urandom_range(0, 7))
                    0: pay = '0;
                    1: pay = '1;
                    2: pay = {8'h80, 16'h8000, 16'h7FFF, 16'h8000};
                    default: pay = {24'($urandom), 32'($urandom)};
                endcase
                pick = $urandom_range(0, 9);
                flaw = (pick < 5) ? FLAW_NONE : t_frame_flaw'(pick - 4);
                len  = msfd_pkg::FIXED_LEN;
                flip = 8'h00;
                t0   = msfd_pkg::TRL0;
                t1   = msfd_pkg::TRL1;
                if (flaw == FLAW_LEN || flaw == FLAW_ALL) begin
                    do len = 8'($urandom); while (len == msfd_pkg::FIXED_LEN);
                end
                if (flaw == FLAW_CRC || flaw == FLAW_ALL)
                    flip = 8'($urandom_range(1, 255));
                if (flaw == FLAW_TRL0) begin
                    do t0 = 8'($urandom); while (t0 == msfd_pkg::TRL0);
                end
                if (flaw == FLAW_TRL1 || flaw == FLAW_ALL) begin
                    do t1 = 8'($urandom); while (t1 == msfd_pkg::TRL1);
                end
                send_frame(len, pay, flip, t0, t1);
                frame_bytes += 13;
                if (frames_sent % 25 == 0)
                    hold_until_drained();
            end else if (pick < 18) begin
                n = $urandom_range(1, 5);
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0: b = msfd_pkg::HDR0;
                        1: b = msfd_pkg::HDR1;
                        default: b = 8'($urandom);
                    endcase
                    send_byte(b);
                end
            end else begin
                // cut a frame short; the next bytes get absorbed as its body
                send_byte(msfd_pkg::HDR0);
                send_byte(msfd_pkg::HDR1);
                n = $urandom_range(0, 10);
                repeat (n) send_byte(8'($urandom));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (frames_due.size() == 0) begin
                    report_mismatch("frame with none due", {8'h00, control_flag}, 16'h0000);
                end else begin
                    frame_head = frames_due.pop_front();
                    if (left_speed !== frame_head.left_speed)
                        report_mismatch("left_speed", left_speed, frame_head.left_speed);
                    if (right_speed !== frame_head.right_speed)
                        report_mismatch("right_speed", right_speed, frame_head.right_speed);
                    if (steer_angle !== frame_head.steer_angle)
                        report_mismatch("steer_angle", steer_angle, frame_head.steer_angle);
                    if (control_flag !== frame_head.control_flag)
                        report_mismatch("control_flag", 16'(control_flag),
                                        16'(frame_head.control_flag));
                    if (status !== frame_head.status)
                        report_mismatch("status", 16'(status), 16'(frame_head.status));
                    status_seen[frame_head.status]++;
                    frames_checked++;
                end
            end
            if (pop_tick == 0)
                stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                            : (16'($urandom) | 16'h0001);
            pop_tick      = (pop_tick + 1) % 64;
            pop          <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_header_hunt();
        test_error_priority();
        hold_until_drained();
        test_random_traffic(920);
        hold_until_drained();
        if (frames_due.size() != 0)
            report_mismatch("frames left due", 16'(frames_due.size()), 16'h0000);
        $display("Sent %0d bytes in %0d framed sequences plus noise; checked %0d frames",
                 bytes_sent, frames_sent, frames_checked);
        $display("Status seen: ok %0d, bad length %0d, bad crc %0d, bad trailer %0d",
                 status_seen[msfd_pkg::ST_OK], status_seen[msfd_pkg::ST_BAD_LEN],
                 status_seen[msfd_pkg::ST_BAD_CRC], status_seen[msfd_pkg::ST_BAD_TRL]);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
